>>> sv/cdz_pkg.sv
// ----------------------------------------------------------------------------
// cdz_pkg
// Shared widths and constants for the circular stick dead zone pipeline.
// ----------------------------------------------------------------------------
package cdz_pkg;

    // The square root resolves one result bit per stage.
    localparam int SQRT_STAGES = 16;
    // The divider resolves one quotient bit per stage.
    localparam int DIV_STAGES  = 16;

    localparam logic [15:0] Q15_MAX  = 16'd32767;
    localparam logic [15:0] Q15_ONE  = 16'd32768;

    typedef logic [15:0] t_mag;
    typedef logic [14:0] t_dz;

endpackage

>>> sv/circular_stick_dead_zone.sv
// Throughput: one word per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Reset clears the stage valid bits and loads the dead zone with 7849.
// ----------------------------------------------------------------------------
// circular_stick_dead_zone
// Circular radial dead zone with rescaling of one thumbstick sample.
// ----------------------------------------------------------------------------
module circular_stick_dead_zone
    import cdz_pkg::*;
#(
    parameter int FULL_SCALE = 32767
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata,      // dead_zone
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // stick_x [15:0], stick_y [31:16]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // out_x [15:0], out_y [31:16]
    output logic        o_m_axis_tuser    // active
);

    localparam int   NVLD = 3 + SQRT_STAGES + 2 + DIV_STAGES + 1;
    localparam t_dz  FS   = t_dz'(FULL_SCALE);

    logic            en;
    t_dz             r_dz;
    logic [NVLD-1:0] r_vld;

    // Stage 0 to 2 registers.
    logic [15:0] r_ax0, r_ay0, r_ax1, r_ay1, r_ax2, r_ay2;
    logic        r_sx0, r_sy0, r_sx1, r_sy1, r_sx2, r_sy2;
    logic [31:0] r_sqx, r_sqy, r_sum;
    // Side data alongside the square root.
    logic [15:0] r_dax [0:SQRT_STAGES-1];
    logic [15:0] r_day [0:SQRT_STAGES-1];
    logic [1:0]  r_dsg [0:SQRT_STAGES-1];
    t_mag        root;
    // Scale stage.
    t_mag        r_mag;
    t_dz         r_m, r_d, n_m, n_d;
    logic        r_act, n_act;
    logic [15:0] r_ax3, r_ay3;
    logic [1:0]  r_sg3;
    t_dz         clamp;
    // Product stage.
    logic [31:0] r_px, r_py;
    logic [30:0] r_den;
    logic [2:0]  r_fl4;
    logic [2:0]  r_dfl [0:DIV_STAGES-1];
    logic [15:0] qx, qy;
    // Output register.
    logic [15:0] r_ox, r_oy;
    logic        r_oact;

    assign en              = !r_vld[NVLD-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Dead zone register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz <= 15'd7849;
        end else if (i_cfg_we) begin
            r_dz <= i_cfg_wdata;
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NVLD-2:0], i_s_axis_tvalid};
        end
    end

    // Absolute values, squares and their sum.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx0 <= i_s_axis_tdata[15];
            r_sy0 <= i_s_axis_tdata[31];
            r_ax0 <= i_s_axis_tdata[15] ? (16'd0 - i_s_axis_tdata[15:0])
                                        : i_s_axis_tdata[15:0];
            r_ay0 <= i_s_axis_tdata[31] ? (16'd0 - i_s_axis_tdata[31:16])
                                        : i_s_axis_tdata[31:16];
            r_sqx <= 32'(r_ax0) * 32'(r_ax0);
            r_sqy <= 32'(r_ay0) * 32'(r_ay0);
            r_ax1 <= r_ax0;
            r_ay1 <= r_ay0;
            r_sx1 <= r_sx0;
            r_sy1 <= r_sy0;
            r_sum <= r_sqx + r_sqy;
            r_ax2 <= r_ax1;
            r_ay2 <= r_ay1;
            r_sx2 <= r_sx1;
            r_sy2 <= r_sy1;
        end
    end

    cdz_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand (r_sum),
        .o_root     (root)
    );

    // Components and signs wait beside the square root.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dax[0] <= r_ax2;
            r_day[0] <= r_ay2;
            r_dsg[0] <= {r_sy2, r_sx2};
            for (int i = 1; i < SQRT_STAGES; i++) begin
                r_dax[i] <= r_dax[i-1];
                r_day[i] <= r_day[i-1];
                r_dsg[i] <= r_dsg[i-1];
            end
        end
    end

    // Dead zone test and rescale terms.
    always_comb begin
        clamp = (root > t_mag'(FS)) ? FS : root[14:0];
        n_act = (root > t_mag'(r_dz));
        if (r_dz >= FS) begin
            n_m = 15'd1;
            n_d = 15'd1;
        end else begin
            n_m = clamp - r_dz;
            n_d = FS - r_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag <= root;
            r_m   <= n_m;
            r_d   <= n_d;
            r_act <= n_act;
            r_ax3 <= r_dax[SQRT_STAGES-1];
            r_ay3 <= r_day[SQRT_STAGES-1];
            r_sg3 <= r_dsg[SQRT_STAGES-1];
        end
    end

    // Numerators and the shared denominator.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px  <= 32'(r_ax3) * 32'(r_m);
            r_py  <= 32'(r_ay3) * 32'(r_m);
            r_den <= 31'(r_d) * 31'(r_mag);
            r_fl4 <= {r_act, r_sg3};
        end
    end

    cdz_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_px),
        .i_den (r_den),
        .o_quo (qx)
    );

    cdz_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_py),
        .i_den (r_den),
        .o_quo (qy)
    );

    // Flags wait beside the dividers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dfl[0] <= r_fl4;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_dfl[i] <= r_dfl[i-1];
            end
        end
    end

    // Sign, saturation and dead zone masking into the output register.
    function automatic logic [15:0] fmt(input logic [15:0] q, input logic neg,
                                        input logic act);
        logic [15:0] r;
        if (!act) begin
            r = '0;
        end else if (neg) begin
            r = 16'd0 - ((q > Q15_ONE) ? Q15_ONE : q);
        end else begin
            r = (q > Q15_MAX) ? Q15_MAX : q;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox   <= fmt(qx, r_dfl[DIV_STAGES-1][0], r_dfl[DIV_STAGES-1][2]);
            r_oy   <= fmt(qy, r_dfl[DIV_STAGES-1][1], r_dfl[DIV_STAGES-1][2]);
            r_oact <= r_dfl[DIV_STAGES-1][2];
        end
    end

    assign o_m_axis_tvalid = r_vld[NVLD-1];
    assign o_m_axis_tdata  = {r_oy, r_ox};
    assign o_m_axis_tuser  = r_oact;

endmodule

>>> sv/cdz_sqrt.sv
// ----------------------------------------------------------------------------
// cdz_sqrt
// Pipelined floor square root of a 32-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module cdz_sqrt
    import cdz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_radicand,
    output t_mag        o_root
);

    logic [31:0] r_v   [0:SQRT_STAGES-1];
    logic [31:0] r_res [0:SQRT_STAGES-1];

    genvar g;
    generate
        for (g = 0; g < SQRT_STAGES; g++) begin : g_stage
            localparam logic [31:0] BIT = 32'd1 << (30 - 2 * g);
            logic [31:0] w_v;
            logic [31:0] w_res;
            logic [31:0] n_v;
            logic [31:0] n_res;

            if (g == 0) begin : g_first
                assign w_v   = i_radicand;
                assign w_res = '0;
            end else begin : g_next
                assign w_v   = r_v[g-1];
                assign w_res = r_res[g-1];
            end

            // One restoring step: try to subtract the trial value.
            always_comb begin
                if (w_v >= w_res + BIT) begin
                    n_v   = w_v - (w_res + BIT);
                    n_res = (w_res >> 1) + BIT;
                end else begin
                    n_v   = w_v;
                    n_res = w_res >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[g]   <= n_v;
                    r_res[g] <= n_res;
                end
            end
        end
    endgenerate

    assign o_root = r_res[SQRT_STAGES-1][15:0];

endmodule

>>> sv/cdz_div.sv
// ----------------------------------------------------------------------------
// cdz_div
// Pipelined divider giving floor(num * 32768 / den) for quotients below 65536.
// ----------------------------------------------------------------------------
module cdz_div
    import cdz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_num,
    input  logic [30:0] i_den,
    output logic [15:0] o_quo
);

    logic [31:0] r_rem [0:DIV_STAGES-1];
    logic [30:0] r_den [0:DIV_STAGES-1];
    logic [15:0] r_quo [0:DIV_STAGES-1];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_stage
            logic [31:0] w_rem;
            logic [30:0] w_den;
            logic [15:0] w_quo;
            logic [31:0] n_rem;
            logic        n_bit;

            if (g == 0) begin : g_first
                assign w_rem = i_num;
                assign w_den = i_den;
                assign w_quo = '0;
            end else begin : g_next
                // The remainder stays below the divisor, so the shift fits.
                assign w_rem = {r_rem[g-1][30:0], 1'b0};
                assign w_den = r_den[g-1];
                assign w_quo = r_quo[g-1];
            end

            // Compare and subtract for one quotient bit.
            always_comb begin
                n_bit = (w_rem >= {1'b0, w_den});
                n_rem = n_bit ? (w_rem - {1'b0, w_den}) : w_rem;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                    r_den[g] <= w_den;
                    r_quo[g] <= {w_quo[14:0], n_bit};
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule
